// ===== hw/rtl/mmgc_pkg.sv =====
// mmgc_pkg: shared constants, opcodes, controller states and the
// command/status structs that join mmgc_ctrl and mmgc_dp. No dependencies.
package mmgc_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 8192;
  localparam int MAX_ROUNDS_DEF   = 1024;

  localparam int OP_W  = 3;
  localparam int NB_W  = 10;
  localparam int WT_W  = 32;
  localparam int VX_W  = 10;
  localparam int OCL_W = 12;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_CLOSE = 3'd1,
    OP_RUN   = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_ISSUE, ST_RD_DATA,
    ST_CLR,
    ST_DM_ISSUE, ST_DM_USE,
    ST_ROUND_START,
    ST_J_ISSUE, ST_J_COL, ST_J_START,
    ST_K_ISSUE, ST_K_NBR, ST_K_CISS, ST_K_COL, ST_K_DEG,
    ST_J_VERD,
    ST_A_ISSUE, ST_A_USE,
    ST_R_END, ST_SUMMARY
  } state_t;

  typedef enum logic [1:0] { CS_VX, CS_I, CS_J } col_sel_t;
  typedef enum logic [1:0] { ES_I, ES_IM1, ES_J, ES_JM1 } end_sel_t;
  typedef enum logic { WS_I, WS_J } wt_sel_t;

  typedef struct packed {
    logic     ld_add;
    logic     ld_close;
    logic     ld_clear;
    logic     rd_latch;
    logic     out_read;
    logic     out_sum;
    logic     run_init;
    logic     clr_step;
    logic     i_inc;
    logic     i_zero;
    logic     dm_step;
    logic     round_start;
    logic     set_kend;
    logic     set_kstart;
    logic     j_latch;
    logic     set_jend;
    logic     upd_wt;
    logic     deg_chk;
    logic     ver_wr;
    logic     assign_step;
    logic     round_end;
    logic     c_step;
    col_sel_t col_sel;
    end_sel_t end_sel;
    wt_sel_t  wt_sel;
  } cmd_t;

  typedef struct packed {
    logic i_lt_n;
    logic k_lt_kend;
    logic blk;
    logic nbr_ok;
    logic col_zero;
    logic col_is_c;
    logic j_eq_i;
    logic rdeg;
    logic left_any;
    logic last_round;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/mmgc_ram.sv =====
// mmgc_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module mmgc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/mmgc_ctrl.sv =====
// mmgc_ctrl: sequencer for load, read and the coloring run.
// Depends on mmgc_pkg; drives mmgc_dp through cmd_t, watches sts_t.
module mmgc_ctrl import mmgc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_stall,
  input  sts_t            sts,
  output cmd_t            cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.col_sel = CS_I;
    cmd.end_sel = ES_I;
    cmd.wt_sel  = WS_I;
    in_stall    = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_ADD:   cmd.ld_add   = 1'b1;
            OP_CLOSE: cmd.ld_close = 1'b1;
            OP_CLEAR: cmd.ld_clear = 1'b1;
            OP_READ: begin
              cmd.rd_latch = 1'b1;
              state_nxt    = ST_RD_ISSUE;
            end
            OP_RUN: begin
              cmd.run_init = 1'b1;
              state_nxt    = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_RD_ISSUE: begin
        cmd.col_sel = CS_VX;
        state_nxt   = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        cmd.col_sel = CS_VX;
        if (sts.out_free) begin
          cmd.out_read = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (sts.i_lt_n) cmd.clr_step = 1'b1;
        else begin
          cmd.i_zero = 1'b1;
          state_nxt  = ST_DM_ISSUE;
        end
      end
      ST_DM_ISSUE: begin
        cmd.end_sel = ES_I;
        state_nxt   = sts.i_lt_n ? ST_DM_USE : ST_ROUND_START;
      end
      ST_DM_USE: begin
        cmd.dm_step = 1'b1;
        state_nxt   = ST_DM_ISSUE;
      end
      ST_ROUND_START: begin
        cmd.round_start = 1'b1;
        state_nxt       = ST_J_ISSUE;
      end
      // judge pass
      ST_J_ISSUE: begin
        cmd.col_sel = CS_I;
        cmd.end_sel = ES_I;
        if (sts.i_lt_n) state_nxt = ST_J_COL;
        else begin
          cmd.i_zero = 1'b1;
          state_nxt  = ST_A_ISSUE;
        end
      end
      ST_J_COL: begin
        cmd.end_sel = ES_IM1;
        cmd.wt_sel  = WS_I;
        if (!sts.col_zero) begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_J_ISSUE;
        end else begin
          cmd.set_kend = 1'b1;
          state_nxt    = ST_J_START;
        end
      end
      ST_J_START: begin
        cmd.set_kstart = 1'b1;
        state_nxt      = ST_K_ISSUE;
      end
      ST_K_ISSUE: begin
        state_nxt = (sts.k_lt_kend && !sts.blk) ? ST_K_NBR : ST_J_VERD;
      end
      ST_K_NBR: begin
        cmd.j_latch = 1'b1;
        state_nxt   = sts.nbr_ok ? ST_K_CISS : ST_K_ISSUE;
      end
      ST_K_CISS: begin
        cmd.col_sel = CS_J;
        cmd.end_sel = ES_J;
        cmd.wt_sel  = WS_J;
        state_nxt   = ST_K_COL;
      end
      ST_K_COL: begin
        cmd.end_sel = ES_JM1;
        if (sts.rdeg) begin
          if (sts.col_zero) begin
            cmd.set_jend = 1'b1;
            state_nxt    = ST_K_DEG;
          end else begin
            state_nxt = ST_K_ISSUE;
          end
        end else begin
          if ((sts.col_zero || sts.col_is_c) && !sts.j_eq_i) cmd.upd_wt = 1'b1;
          state_nxt = ST_K_ISSUE;
        end
      end
      ST_K_DEG: begin
        cmd.deg_chk = 1'b1;
        state_nxt   = ST_K_ISSUE;
      end
      ST_J_VERD: begin
        cmd.ver_wr = 1'b1;
        cmd.i_inc  = 1'b1;
        state_nxt  = ST_J_ISSUE;
      end
      // assign pass
      ST_A_ISSUE: begin
        cmd.col_sel = CS_I;
        state_nxt   = sts.i_lt_n ? ST_A_USE : ST_R_END;
      end
      ST_A_USE: begin
        cmd.assign_step = 1'b1;
        cmd.i_inc       = 1'b1;
        state_nxt       = ST_A_ISSUE;
      end
      ST_R_END: begin
        cmd.round_end = 1'b1;
        if (!sts.left_any || sts.last_round) state_nxt = ST_SUMMARY;
        else begin
          cmd.c_step = 1'b1;
          state_nxt  = ST_ROUND_START;
        end
      end
      ST_SUMMARY: begin
        if (sts.out_free) begin
          cmd.out_sum = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/mmgc_dp.sv =====
// mmgc_dp: graph stores, round registers, comparators and output register.
// Depends on mmgc_pkg and mmgc_ram; steered by mmgc_ctrl via cmd_t.
module mmgc_dp import mmgc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int MAX_ROUNDS   = MAX_ROUNDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [NB_W-1:0]  in_neighbor,
  input  logic [WT_W-1:0]  in_weight,
  input  logic [VX_W-1:0]  in_vertex,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             out_kind,
  output logic [OCL_W-1:0] out_color,
  output logic [OCL_W-1:0] out_color_count,
  output logic             out_complete,
  output logic             out_overflow
);
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int CW  = $clog2(2 * MAX_ROUNDS + 1);
  localparam int RW  = $clog2(MAX_ROUNDS + 1);
  localparam int NW  = $clog2(2 * MAX_ROUNDS + 2);

  localparam logic [VW:0]   N_FULL = (VW+1)'(MAX_VERTICES);
  localparam logic [EW-1:0] E_FULL = EW'(MAX_EDGES);
  localparam logic [RW-1:0] R_LAST = RW'(MAX_ROUNDS - 1);

  // graph size and flags
  logic [VW:0]     n_r;
  logic [EW-1:0]   e_r;
  logic            ovf_r, dmode_r, dhit_r, rdeg_r;
  logic [CW-1:0]   c_r;
  logic [RW-1:0]   round_r;
  logic [NW-1:0]   cnt_r;
  logic            hit_r, used_a_r, used_b_r, left_any_r;
  // walk registers
  logic [VW:0]     i_r;
  logic [EW-1:0]   k_r, kend_r, jend_r, prevend_r, prevdeg_r;
  logic [NB_W-1:0] j_r;
  logic [VX_W-1:0] vx_r;
  logic [WT_W-1:0] mine_r, hi_r, lo_r;
  logic            any_r, blk_r;
  // output word
  logic             out_valid_r, out_kind_r, out_complete_r, out_overflow_r;
  logic [OCL_W-1:0] out_color_r, out_count_r;

  // RAM ports
  logic [NB_W-1:0] nbr_rdata;
  logic [EW-1:0]   end_rdata;
  logic [WT_W-1:0] wt_rdata;
  logic [CW-1:0]   col_rdata;
  logic [1:0]      ver_rdata;
  logic            col_we;
  logic [VW-1:0]   col_waddr, col_raddr, end_raddr, wt_raddr;
  logic [CW-1:0]   col_wdata;
  logic            load_ok, add_ok;

  assign load_ok = (n_r != N_FULL);
  assign add_ok  = load_ok && (e_r != E_FULL);

  mmgc_ram #(.W(NB_W), .D(MAX_EDGES)) u_nbr (
    .clk(clk), .we(cmd.ld_add && add_ok), .waddr(e_r[EAW-1:0]),
    .wdata(in_neighbor), .raddr(k_r[EAW-1:0]), .rdata(nbr_rdata));

  // end of row v = start of row v+1
  mmgc_ram #(.W(EW), .D(MAX_VERTICES)) u_end (
    .clk(clk), .we(cmd.ld_close && load_ok), .waddr(n_r[VW-1:0]),
    .wdata(e_r), .raddr(end_raddr), .rdata(end_rdata));

  mmgc_ram #(.W(WT_W), .D(MAX_VERTICES)) u_wt (
    .clk(clk), .we(cmd.ld_close && load_ok), .waddr(n_r[VW-1:0]),
    .wdata(in_weight), .raddr(wt_raddr), .rdata(wt_rdata));

  mmgc_ram #(.W(CW), .D(MAX_VERTICES)) u_col (
    .clk(clk), .we(col_we), .waddr(col_waddr),
    .wdata(col_wdata), .raddr(col_raddr), .rdata(col_rdata));

  mmgc_ram #(.W(2), .D(MAX_VERTICES)) u_ver (
    .clk(clk), .we(cmd.ver_wr), .waddr(i_r[VW-1:0]),
    .wdata(blk_r ? 2'b00 : {!any_r || (mine_r < lo_r), !any_r || (mine_r > hi_r)}),
    .raddr(i_r[VW-1:0]), .rdata(ver_rdata));

  always_comb begin
    case (cmd.col_sel)
      CS_VX:   col_raddr = VW'(vx_r);
      CS_J:    col_raddr = VW'(j_r);
      default: col_raddr = i_r[VW-1:0];
    endcase
    case (cmd.end_sel)
      ES_IM1:  end_raddr = i_r[VW-1:0] - VW'(1);
      ES_J:    end_raddr = VW'(j_r);
      ES_JM1:  end_raddr = VW'(j_r) - VW'(1);
      default: end_raddr = i_r[VW-1:0];
    endcase
    wt_raddr = (cmd.wt_sel == WS_J) ? VW'(j_r) : i_r[VW-1:0];
  end

  always_comb begin
    col_we    = 1'b0;
    col_waddr = i_r[VW-1:0];
    col_wdata = '0;
    if (cmd.ld_close && load_ok) begin
      col_we    = 1'b1;
      col_waddr = n_r[VW-1:0];
    end else if (cmd.clr_step) begin
      col_we = 1'b1;
    end else if (cmd.assign_step && col_rdata == '0 && ver_rdata != 2'b00) begin
      col_we    = 1'b1;
      col_wdata = ver_rdata[0] ? c_r : c_r + CW'(1);
    end
  end

  // neighbor compare value and degree helpers
  logic [EW-1:0]   kstart, jstart;
  logic [WT_W-1:0] other;
  logic            take_upd;
  assign kstart   = (i_r == '0) ? '0 : end_rdata;
  assign jstart   = (j_r == '0) ? '0 : end_rdata;
  assign other    = cmd.deg_chk ? WT_W'(jend_r - jstart) : wt_rdata;
  assign take_upd = cmd.upd_wt || (cmd.deg_chk && other != mine_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      e_r         <= '0;
      ovf_r       <= 1'b0;
      c_r         <= CW'(1);
      dmode_r     <= 1'b0;
      dhit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.ld_add) begin
        if (add_ok) e_r <= e_r + EW'(1);
        else        ovf_r <= 1'b1;
      end
      if (cmd.ld_close) begin
        if (load_ok) n_r <= n_r + (VW+1)'(1);
        else         ovf_r <= 1'b1;
      end
      if (cmd.ld_clear) begin
        n_r     <= '0;
        e_r     <= '0;
        ovf_r   <= 1'b0;
        c_r     <= CW'(1);
        dmode_r <= 1'b0;
        dhit_r  <= 1'b0;
      end
      if (cmd.run_init) begin
        c_r     <= CW'(1);
        dmode_r <= 1'b0;
        dhit_r  <= 1'b0;
      end
      if (cmd.dm_step && i_r != '0 && (end_rdata - prevend_r) != prevdeg_r)
        dmode_r <= 1'b1;
      if (cmd.round_end && rdeg_r) begin
        dhit_r <= hit_r;
        if (!hit_r) dmode_r <= 1'b0;
      end
      if (cmd.c_step) c_r <= c_r + CW'(2);
      if (cmd.out_read || cmd.out_sum) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_latch) vx_r <= in_vertex;
    if (cmd.run_init) begin
      i_r       <= '0;
      prevend_r <= '0;
      round_r   <= '0;
      cnt_r     <= '0;
    end
    if (cmd.clr_step || cmd.i_inc) i_r <= i_r + (VW+1)'(1);
    if (cmd.i_zero) i_r <= '0;
    if (cmd.dm_step) begin
      prevdeg_r <= end_rdata - prevend_r;
      prevend_r <= end_rdata;
      i_r       <= i_r + (VW+1)'(1);
    end
    if (cmd.round_start) begin
      i_r        <= '0;
      rdeg_r     <= dhit_r || dmode_r;
      hit_r      <= 1'b0;
      used_a_r   <= 1'b0;
      used_b_r   <= 1'b0;
      left_any_r <= 1'b0;
    end
    if (cmd.set_kend) kend_r <= end_rdata;
    if (cmd.set_kstart) begin
      k_r    <= kstart;
      mine_r <= rdeg_r ? WT_W'(kend_r - kstart) : wt_rdata;
      any_r  <= 1'b0;
      blk_r  <= 1'b0;
    end
    if (cmd.j_latch) begin
      j_r <= nbr_rdata;
      k_r <= k_r + EW'(1);
    end
    if (cmd.set_jend) jend_r <= end_rdata;
    if (cmd.deg_chk && other == mine_r) blk_r <= 1'b1;
    if (take_upd) begin
      if (!any_r || other > hi_r) hi_r <= other;
      if (!any_r || other < lo_r) lo_r <= other;
      any_r <= 1'b1;
    end
    if (cmd.assign_step && col_rdata == '0) begin
      if (ver_rdata[0]) begin
        hit_r    <= 1'b1;
        used_a_r <= 1'b1;
      end else if (ver_rdata[1]) begin
        hit_r    <= 1'b1;
        used_b_r <= 1'b1;
      end else begin
        left_any_r <= 1'b1;
      end
    end
    if (cmd.round_end) begin
      cnt_r   <= cnt_r + NW'(used_a_r) + NW'(used_b_r);
      round_r <= round_r + RW'(1);
    end
    if (cmd.out_read) begin
      out_kind_r     <= 1'b1;
      out_color_r    <= (32'(vx_r) < 32'(n_r)) ? OCL_W'(col_rdata) : '0;
      out_count_r    <= '0;
      out_complete_r <= 1'b0;
      out_overflow_r <= 1'b0;
    end
    if (cmd.out_sum) begin
      out_kind_r     <= 1'b0;
      out_color_r    <= '0;
      out_count_r    <= OCL_W'(cnt_r + NW'(left_any_r));
      out_complete_r <= !left_any_r;
      out_overflow_r <= ovf_r;
    end
  end

  always_comb begin
    sts.i_lt_n     = (i_r < n_r);
    sts.k_lt_kend  = (k_r < kend_r);
    sts.blk        = blk_r;
    sts.nbr_ok     = (32'(nbr_rdata) < 32'(n_r));
    sts.col_zero   = (col_rdata == '0);
    sts.col_is_c   = (col_rdata == c_r);
    sts.j_eq_i     = (32'(j_r) == 32'(i_r));
    sts.rdeg       = rdeg_r;
    sts.left_any   = left_any_r;
    sts.last_round = (round_r == R_LAST);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_color       = out_color_r;
  assign out_color_count = out_count_r;
  assign out_complete    = out_complete_r;
  assign out_overflow    = out_overflow_r;
endmodule

// ===== hw/rtl/min_max_graph_coloring.sv =====
// min_max_graph_coloring: top level, sequencer plus datapath.
// Depends on mmgc_pkg, mmgc_ctrl, mmgc_dp (and mmgc_ram below it).
//
// Use: one input channel (in_valid/in_stall) carries command words
// (op, neighbor, weight, vertex); one output channel (out_valid/out_stall)
// carries result words. A graph is loaded row by row: add-neighbor words,
// then a close word with the vertex weight. Load and clear words leave the
// sequencer idle, so they stream back to back. A read answer word is
// loaded into the output register in the read-data state, after the
// read-issue state, once that register is free. A run word walks the graph
// in the sequencer: it clears the colors, compares the degrees, then per
// round runs a judge pass over every vertex, walking the adjacency entries
// of each uncolored one, then an assign pass over every vertex and the
// round end; rounds repeat until all vertices are colored or MAX_ROUNDS
// is reached. Input is stalled for the whole read or run. The results go
// through one output register: a pending word holds while out_stall is
// high, loads continue meanwhile, and a read or run waits at its end for
// the register to free. Reset empties the graph, clears the overflow flag
// and drops any pending result word; no memory sweep is run.
module min_max_graph_coloring import mmgc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int MAX_ROUNDS   = MAX_ROUNDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OP_W-1:0]  in_op,
  input  logic [NB_W-1:0]  in_neighbor,
  input  logic [WT_W-1:0]  in_weight,
  input  logic [VX_W-1:0]  in_vertex,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [OCL_W-1:0] out_color,
  output logic [OCL_W-1:0] out_color_count,
  output logic             out_complete,
  output logic             out_overflow
);
  cmd_t cmd;
  sts_t sts;

  // sequencer: one state per memory access step
  mmgc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_op(in_op),
    .in_stall(in_stall), .sts(sts), .cmd(cmd));

  // stores, comparators, round bookkeeping and the output word
  mmgc_dp #(
    .MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES), .MAX_ROUNDS(MAX_ROUNDS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_neighbor(in_neighbor), .in_weight(in_weight), .in_vertex(in_vertex),
    .out_stall(out_stall), .out_valid(out_valid), .out_kind(out_kind),
    .out_color(out_color), .out_color_count(out_color_count),
    .out_complete(out_complete), .out_overflow(out_overflow));
endmodule
